@@ src/iatv_pkg.sv @@
// Shared types and constants for the IP address text validator.
// Used by the classifier, the queue and the checker; depends on nothing.
package iatv_pkg;

    // Character codes of interest.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Class of the previous character seen by the IPv6 check.
    localparam logic [1:0] CLS_START  = 2'd0;
    localparam logic [1:0] CLS_HEX    = 2'd1;
    localparam logic [1:0] CLS_COLON  = 2'd2;
    localparam logic [1:0] CLS_DCOLON = 2'd3;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic       is_dec;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_colon;
        logic       is_dot;
        logic       is_nul;
        logic       last;
    } t_char_cls;

endpackage

@@ src/iatv_char_if.sv @@
// Character channel: one address character per beat with a last mark.
// No dependencies.
interface iatv_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ src/iatv_verdict_if.sv @@
// Verdict channel: one beat per address string with the two results.
// No dependencies.
interface iatv_verdict_if;
    logic valid;
    logic ready;
    logic is_ipv4;
    logic is_ipv6;

    modport source (output valid, output is_ipv4, output is_ipv6, input ready);
    modport sink   (input valid, input is_ipv4, input is_ipv6, output ready);
endinterface

@@ src/iatv_classifier.sv @@
// Front end: decodes one character into its class and hex digit value.
// Depends on iatv_pkg.
module iatv_classifier
    import iatv_pkg::*;
(
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output t_char_cls  o_cls
);

    logic is_dec;
    logic is_alpha;

    always_comb begin
        is_dec   = 1'b0;
        is_alpha = 1'b0;
        case (i_char_code) inside
            [8'h30:8'h39]: is_dec   = 1'b1;
            [8'h41:8'h46]: is_alpha = 1'b1;
            [8'h61:8'h66]: is_alpha = 1'b1;
            default: begin
                is_dec   = 1'b0;
                is_alpha = 1'b0;
            end
        endcase
    end

    // For 'a'..'f' and 'A'..'F' the low nibble runs from 1, so adding nine gives 10..15.
    assign o_cls.is_dec   = is_dec;
    assign o_cls.is_hex   = is_dec | is_alpha;
    assign o_cls.hex_val  = is_dec ? i_char_code[3:0] : i_char_code[3:0] + 4'd9;
    assign o_cls.is_colon = (i_char_code == CH_COLON);
    assign o_cls.is_dot   = (i_char_code == CH_DOT);
    assign o_cls.is_nul   = (i_char_code == CH_NUL);
    assign o_cls.last     = i_last_char;

endmodule

@@ src/iatv_queue.sv @@
// Short queue of classified characters between the front and the back end.
// Depends on iatv_pkg.
module iatv_queue
    import iatv_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_char_cls i_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_char_cls o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_char_cls         r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     n_wr_ptr;
    logic [AW-1:0]     n_rd_ptr;
    logic [CW-1:0]     n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ src/iatv_checker.sv @@
// Back end: runs the IPv4 and IPv6 checks on classified characters and
// holds the verdict in an output register. Depends on iatv_pkg.
module iatv_checker
    import iatv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_char_cls i_cls,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output logic      o_is_ipv4,
    output logic      o_is_ipv6
);

    function automatic logic [8:0] f_dec_acc(input logic [8:0] v, input logic [3:0] d);
        logic [11:0] s;
        s = {v, 3'b000} + {2'b00, v, 1'b0} + {8'h00, d};
        return (s > 12'd256) ? 9'd256 : s[8:0];
    endfunction

    function automatic logic [16:0] f_hex_acc(input logic [16:0] v, input logic [3:0] d);
        logic [20:0] s;
        s = {v, 4'h0} + {17'h00000, d};
        return (s > 21'h10000) ? 17'h10000 : s[16:0];
    endfunction

    logic [8:0]  r_q_val,   n_q_val;
    logic [1:0]  r_q_dots,  n_q_dots;
    logic        r_q_ne,    n_q_ne;
    logic        r_q_fail,  n_q_fail;
    logic [16:0] r_h_val,   n_h_val;
    logic [3:0]  r_h_cnt,   n_h_cnt;
    logic        r_dcolon,  n_dcolon;
    logic [1:0]  r_prev,    n_prev;
    logic        r_h_fail,  n_h_fail;
    logic [8:0]  r_t_val,   n_t_val;
    logic [1:0]  r_t_dots,  n_t_dots;
    logic        r_t_ne,    n_t_ne;
    logic        r_t_fail,  n_t_fail;
    logic        r_t_act,   n_t_act;
    logic        r_ended,   n_ended;
    logic        r_out_valid;
    logic        r_is_ipv4;
    logic        r_is_ipv6;
    logic        v4_ok;
    logic        v6_ok;
    logic [3:0]  groups;
    logic        groups_ok;
    logic        take;

    // A character that yields no verdict may pass while the output still waits.
    assign take  = i_valid && (!i_cls.last || !r_out_valid || i_ready);
    assign o_pop = take;

    always_comb begin
        n_q_val  = r_q_val;
        n_q_dots = r_q_dots;
        n_q_ne   = r_q_ne;
        n_q_fail = r_q_fail;
        n_h_val  = r_h_val;
        n_h_cnt  = r_h_cnt;
        n_dcolon = r_dcolon;
        n_prev   = r_prev;
        n_h_fail = r_h_fail;
        n_t_val  = r_t_val;
        n_t_dots = r_t_dots;
        n_t_ne   = r_t_ne;
        n_t_fail = r_t_fail;
        n_t_act  = r_t_act;
        n_ended  = r_ended;

        if (!r_ended) begin
            if (i_cls.is_nul) begin
                n_ended = 1'b1;
            end else begin
                // Dotted-quad check.
                if (i_cls.is_dec) begin
                    n_q_val = f_dec_acc(r_q_val, i_cls.hex_val);
                    n_q_ne  = 1'b1;
                end else if (i_cls.is_dot) begin
                    if (!r_q_ne || r_q_val > 9'd255 || r_q_dots == 2'd3) begin
                        n_q_fail = 1'b1;
                    end else begin
                        n_q_dots = r_q_dots + 2'd1;
                    end
                    n_q_val = '0;
                    n_q_ne  = 1'b0;
                end else begin
                    n_q_fail = 1'b1;
                end

                // IPv6 check; once failed nothing more changes.
                if (!r_h_fail) begin
                    if (r_t_act) begin
                        if (i_cls.is_dec) begin
                            n_t_val = f_dec_acc(r_t_val, i_cls.hex_val);
                            n_t_ne  = 1'b1;
                        end else if (i_cls.is_dot) begin
                            if (!r_t_ne || r_t_val > 9'd255 || r_t_dots == 2'd3) begin
                                n_h_fail = 1'b1;
                            end else begin
                                n_t_dots = r_t_dots + 2'd1;
                            end
                            n_t_val = '0;
                            n_t_ne  = 1'b0;
                        end else begin
                            n_h_fail = 1'b1;
                        end
                    end else if (i_cls.is_hex) begin
                        if (r_prev == CLS_COLON && r_h_cnt == 4'd0 && !r_dcolon) begin
                            n_h_fail = 1'b1;
                        end else begin
                            n_h_val = f_hex_acc(r_h_val, i_cls.hex_val);
                            if (i_cls.is_dec) begin
                                n_t_val = f_dec_acc(r_t_val, i_cls.hex_val);
                                n_t_ne  = 1'b1;
                            end else begin
                                n_t_fail = 1'b1;
                            end
                            n_prev = CLS_HEX;
                        end
                    end else if (i_cls.is_colon) begin
                        case (r_prev)
                            CLS_START: begin
                                n_prev = CLS_COLON;
                            end
                            CLS_HEX: begin
                                if (r_h_val > 17'h0FFFF || r_h_cnt >= 4'd8) begin
                                    n_h_fail = 1'b1;
                                end else begin
                                    n_h_cnt  = r_h_cnt + 4'd1;
                                    n_h_val  = '0;
                                    n_t_val  = '0;
                                    n_t_ne   = 1'b0;
                                    n_t_fail = 1'b0;
                                    n_prev   = CLS_COLON;
                                end
                            end
                            CLS_COLON: begin
                                if (r_dcolon) begin
                                    n_h_fail = 1'b1;
                                end
                                n_dcolon = 1'b1;
                                n_prev   = CLS_DCOLON;
                            end
                            default: begin
                                n_h_fail = 1'b1;
                            end
                        endcase
                    end else if (i_cls.is_dot) begin
                        if (r_prev != CLS_HEX || (r_h_cnt == 4'd0 && !r_dcolon) || r_t_fail
                                || !r_t_ne || r_t_val > 9'd255) begin
                            n_h_fail = 1'b1;
                        end else begin
                            n_t_act  = 1'b1;
                            n_t_dots = 2'd1;
                            n_t_val  = '0;
                            n_t_ne   = 1'b0;
                        end
                    end else begin
                        n_h_fail = 1'b1;
                    end
                end
            end
        end
    end

    // Verdicts from the state after this character.
    always_comb begin
        v4_ok = !n_q_fail && n_q_dots == 2'd3 && n_q_ne && n_q_val <= 9'd255;

        groups    = '0;
        groups_ok = 1'b0;
        if (n_t_act) begin
            groups    = n_h_cnt + 4'd2;
            groups_ok = n_t_dots == 2'd3 && n_t_ne && n_t_val <= 9'd255;
        end else if (n_prev == CLS_HEX) begin
            groups    = n_h_cnt + 4'd1;
            groups_ok = n_h_val <= 17'h0FFFF;
        end else if (n_prev == CLS_DCOLON) begin
            groups    = n_h_cnt;
            groups_ok = 1'b1;
        end

        if (n_dcolon) begin
            v6_ok = !n_h_fail && groups_ok && groups >= 4'd1 && groups <= 4'd7;
        end else begin
            v6_ok = !n_h_fail && groups_ok && groups == 4'd8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && i_cls.last)) begin
            r_q_val  <= '0;
            r_q_dots <= '0;
            r_q_ne   <= 1'b0;
            r_q_fail <= 1'b0;
            r_h_val  <= '0;
            r_h_cnt  <= '0;
            r_dcolon <= 1'b0;
            r_prev   <= CLS_START;
            r_h_fail <= 1'b0;
            r_t_val  <= '0;
            r_t_dots <= '0;
            r_t_ne   <= 1'b0;
            r_t_fail <= 1'b0;
            r_t_act  <= 1'b0;
            r_ended  <= 1'b0;
        end else if (take) begin
            r_q_val  <= n_q_val;
            r_q_dots <= n_q_dots;
            r_q_ne   <= n_q_ne;
            r_q_fail <= n_q_fail;
            r_h_val  <= n_h_val;
            r_h_cnt  <= n_h_cnt;
            r_dcolon <= n_dcolon;
            r_prev   <= n_prev;
            r_h_fail <= n_h_fail;
            r_t_val  <= n_t_val;
            r_t_dots <= n_t_dots;
            r_t_ne   <= n_t_ne;
            r_t_fail <= n_t_fail;
            r_t_act  <= n_t_act;
            r_ended  <= n_ended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_cls.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_cls.last) begin
            r_is_ipv4 <= v4_ok;
            r_is_ipv6 <= v6_ok;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_is_ipv4 = r_is_ipv4;
    assign o_is_ipv6 = r_is_ipv6;

endmodule

@@ src/ip_address_text_validator.sv @@
// IP address text validator: one character beat per cycle in, one verdict beat per string.
// Path: the last character passes through the queue into the checker, which loads the verdict
// into its output register; the check itself is a registered state update per character.
// Throughput: one character per cycle, held off while the queue is full or a verdict waits.
// Reset (synchronous, active low) empties the queue and the output, and clears the check state.
// Depends on iatv_pkg, iatv_char_if, iatv_verdict_if and the three iatv modules.
module ip_address_text_validator
    import iatv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    iatv_char_if.sink             i_char,
    iatv_verdict_if.source        o_verdict
);

    t_char_cls cls_in;
    t_char_cls cls_out;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    logic      push;

    assign i_char.ready = !q_full;
    assign push         = i_char.valid && !q_full;

    iatv_classifier u_classifier (
        .i_char_code (i_char.char_code),
        .i_last_char (i_char.last_char),
        .o_cls       (cls_in)
    );

    iatv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (cls_out)
    );

    iatv_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_cls     (cls_out),
        .o_pop     (q_pop),
        .o_valid   (o_verdict.valid),
        .i_ready   (o_verdict.ready),
        .o_is_ipv4 (o_verdict.is_ipv4),
        .o_is_ipv6 (o_verdict.is_ipv6)
    );

endmodule
